// ===== rtl/mesh_vertex_normal_accumulator_unit_macros.svh =====
// Assertion macros for the mesh vertex normal accumulator.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef MESH_VERTEX_NORMAL_ACCUMULATOR_UNIT_MACROS_SVH
`define MESH_VERTEX_NORMAL_ACCUMULATOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define MVNA_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("mvna check failed");
// next-cycle implication
`define MVNA_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("mvna check failed");
`else
`define MVNA_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define MVNA_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif
`endif

// ===== rtl/mvna_pkg.sv =====
// Shared types and constants for the mesh vertex normal accumulator.
// No dependencies.
`timescale 1ns / 1ps
package mvna_pkg;
    localparam int VERTEX_COUNT_DEF = 1024;
    localparam int IDX_W   = 10;
    localparam int POS_W   = 16;
    localparam int DIFF_W  = POS_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int CROSS_W = PROD_W + 1;
    localparam int ACC_W   = 48;
    localparam int MAG_W   = 40;
    localparam int NRM_W   = 16;

    localparam logic [1:0] OPC_LOAD   = 2'd0;
    localparam logic [1:0] OPC_FACE   = 2'd1;
    localparam logic [1:0] OPC_READ   = 2'd2;
    localparam logic [1:0] OPC_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]              opcode;
        logic [IDX_W-1:0]        vertex_index;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic [IDX_W-1:0]        face_a;
        logic [IDX_W-1:0]        face_b;
        logic [IDX_W-1:0]        face_c;
    } req_t;

    typedef struct packed {
        logic signed [NRM_W-1:0] normal_x;
        logic signed [NRM_W-1:0] normal_y;
        logic signed [NRM_W-1:0] normal_z;
        logic [MAG_W-1:0]        magnitude;
        logic                    degenerate;
        logic                    from_face;
    } rsp_t;

    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_FACE = 2'd1,
        CMD_READ = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t               kind;
        logic [IDX_W-1:0]        idx_a;
        logic [IDX_W-1:0]        idx_b;
        logic [IDX_W-1:0]        idx_c;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
    } cmd_t;

    typedef struct packed {
        logic signed [NRM_W-1:0] x;
        logic signed [NRM_W-1:0] y;
        logic signed [NRM_W-1:0] z;
        logic [MAG_W-1:0]        mag;
        logic                    degenerate;
    } norm_res_t;
endpackage

// ===== rtl/mvna_front.sv =====
// Front end: accepts request transfers, decodes the opcode and queues commands.
// Depends on mvna_pkg.
`timescale 1ns / 1ps
module mvna_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  mvna_pkg::req_t     req,
    input  logic               hold,
    output logic               cmd_valid,
    input  logic               cmd_ready,
    output mvna_pkg::cmd_t     cmd
);
    localparam int Q_DEPTH = 2;
    localparam int Q_PW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    mvna_pkg::cmd_t   queue_reg [Q_DEPTH];
    logic [Q_PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [Q_PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [Q_CW-1:0]  count_reg, count_next;
    mvna_pkg::cmd_t   cmd_in;
    logic             accept;
    logic             push;
    logic             pop;

    assign req_ready = (count_reg != Q_CW'(Q_DEPTH)) && !hold;
    assign accept    = req_valid && req_ready;
    assign cmd_valid = (count_reg != '0);
    assign cmd       = queue_reg[rd_ptr_reg];
    assign pop       = cmd_valid && cmd_ready;

    // opcode 3 is taken and dropped
    always_comb
    begin
        push         = 1'b0;
        cmd_in.kind  = mvna_pkg::CMD_LOAD;
        cmd_in.idx_a = req.vertex_index;
        cmd_in.idx_b = '0;
        cmd_in.idx_c = '0;
        cmd_in.pos_x = req.pos_x;
        cmd_in.pos_y = req.pos_y;
        cmd_in.pos_z = req.pos_z;
        unique case (req.opcode)
            mvna_pkg::OPC_LOAD:
            begin
                push = accept;
            end
            mvna_pkg::OPC_FACE:
            begin
                push         = accept;
                cmd_in.kind  = mvna_pkg::CMD_FACE;
                cmd_in.idx_a = req.face_a;
                cmd_in.idx_b = req.face_b;
                cmd_in.idx_c = req.face_c;
            end
            mvna_pkg::OPC_READ:
            begin
                push        = accept;
                cmd_in.kind = mvna_pkg::CMD_READ;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + Q_CW'(push) - Q_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= cmd_in;
        end
    end
endmodule

// ===== rtl/mvna_norm.sv =====
// Normalising unit: sum of squares, bit-serial square root, three serial dividers.
// Depends on mvna_pkg.
`timescale 1ns / 1ps
module mvna_norm (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [mvna_pkg::ACC_W-1:0]  vx,
    input  logic signed [mvna_pkg::ACC_W-1:0]  vy,
    input  logic signed [mvna_pkg::ACC_W-1:0]  vz,
    output logic                               done,
    output mvna_pkg::norm_res_t                res
);
    localparam int AW     = mvna_pkg::ACC_W;
    localparam int HW     = AW / 2;
    localparam int S_W    = 2 * AW;
    localparam int REM_W  = AW + 3;
    localparam int QW     = mvna_pkg::NRM_W;
    localparam int DIV_W  = AW + QW + 1;
    localparam int CW     = $clog2(S_W / 2);
    localparam int SQ_LAST = 9;

    localparam logic [1:0] PART_HH = 2'd0;
    localparam logic [1:0] PART_HL = 2'd1;
    localparam logic [1:0] PART_LL = 2'd2;

    typedef enum logic [5:0] {
        N_IDLE = 6'b000001,
        N_SQ   = 6'b000010,
        N_SQRT = 6'b000100,
        N_PREP = 6'b001000,
        N_DIV  = 6'b010000,
        N_FIN  = 6'b100000
    } nstate_t;

    nstate_t          state_reg, state_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [AW-1:0]    mag_reg [3];
    logic             neg_reg [3];
    logic [AW-1:0]    prod_reg;
    logic [1:0]       part_reg;
    logic [S_W-1:0]   s_reg;
    logic [REM_W-1:0] rem_reg;
    logic [AW-1:0]    root_reg;
    logic [DIV_W-1:0] drem_reg [3];
    logic [QW-1:0]    q_reg [3];
    logic [DIV_W-1:0] dsh_reg;

    logic [1:0]       sel_lane;
    logic [1:0]       sel_part;
    logic [HW-1:0]    mul_a, mul_b;
    logic [AW-1:0]    mul_p;
    logic [S_W-1:0]   addend;
    logic [REM_W-1:0] rem_try, trial;
    logic             root_bit;
    logic signed [AW-1:0] vin [3];
    logic signed [QW-1:0] nrm [3];

    assign vin[0] = vx;
    assign vin[1] = vy;
    assign vin[2] = vz;

    always_comb
    begin
        sel_lane = 2'd0;
        sel_part = PART_HH;
        case (cnt_reg)
            CW'(0): begin sel_lane = 2'd0; sel_part = PART_HH; end
            CW'(1): begin sel_lane = 2'd0; sel_part = PART_HL; end
            CW'(2): begin sel_lane = 2'd0; sel_part = PART_LL; end
            CW'(3): begin sel_lane = 2'd1; sel_part = PART_HH; end
            CW'(4): begin sel_lane = 2'd1; sel_part = PART_HL; end
            CW'(5): begin sel_lane = 2'd1; sel_part = PART_LL; end
            CW'(6): begin sel_lane = 2'd2; sel_part = PART_HH; end
            CW'(7): begin sel_lane = 2'd2; sel_part = PART_HL; end
            default: begin sel_lane = 2'd2; sel_part = PART_LL; end
        endcase
    end

    always_comb
    begin
        logic [AW-1:0] m;
        case (sel_lane)
            2'd0:    m = mag_reg[0];
            2'd1:    m = mag_reg[1];
            default: m = mag_reg[2];
        endcase
        mul_a = (sel_part == PART_LL) ? m[HW-1:0] : m[AW-1:HW];
        mul_b = (sel_part == PART_HH) ? m[AW-1:HW] : m[HW-1:0];
    end

    assign mul_p = mul_a * mul_b;

    // cross term is 2*hi*lo, hence the extra shift
    always_comb
    begin
        case (part_reg)
            PART_HH: addend = S_W'(prod_reg) << AW;
            PART_HL: addend = S_W'(prod_reg) << (HW + 1);
            default: addend = S_W'(prod_reg);
        endcase
    end

    assign rem_try  = {rem_reg[REM_W-3:0], s_reg[S_W-1 -: 2]};
    assign trial    = REM_W'({root_reg, 2'b01});
    assign root_bit = (rem_try >= trial);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            N_IDLE:
            begin
                if (start)
                begin
                    state_next = N_SQ;
                    cnt_next   = '0;
                end
            end
            N_SQ:
            begin
                if (cnt_reg == CW'(SQ_LAST))
                begin
                    state_next = N_SQRT;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            N_SQRT:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(S_W / 2 - 1))
                begin
                    state_next = N_PREP;
                end
            end
            N_PREP:
            begin
                cnt_next   = '0;
                state_next = (root_reg == '0) ? N_FIN : N_DIV;
            end
            N_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(QW - 1))
                begin
                    state_next = N_FIN;
                end
            end
            N_FIN:
            begin
                state_next = N_IDLE;
            end
            default:
            begin
                state_next = N_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            N_IDLE:
            begin
                if (start)
                begin
                    for (int n = 0; n < 3; n++)
                    begin
                        neg_reg[n] <= vin[n][AW-1];
                        mag_reg[n] <= vin[n][AW-1] ? AW'(-vin[n]) : vin[n];
                    end
                    s_reg <= '0;
                end
            end
            N_SQ:
            begin
                prod_reg <= mul_p;
                part_reg <= sel_part;
                if (cnt_reg != '0)
                begin
                    s_reg <= s_reg + addend;
                end
                rem_reg  <= '0;
                root_reg <= '0;
            end
            N_SQRT:
            begin
                s_reg <= s_reg << 2;
                if (root_bit)
                begin
                    rem_reg  <= rem_try - trial;
                    root_reg <= {root_reg[AW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_try;
                    root_reg <= {root_reg[AW-2:0], 1'b0};
                end
            end
            N_PREP:
            begin
                dsh_reg <= DIV_W'(root_reg) << QW;
                for (int n = 0; n < 3; n++)
                begin
                    drem_reg[n] <= (DIV_W'(mag_reg[n]) << QW) + DIV_W'(root_reg);
                    q_reg[n]    <= '0;
                end
            end
            N_DIV:
            begin
                dsh_reg <= dsh_reg >> 1;
                for (int n = 0; n < 3; n++)
                begin
                    if (drem_reg[n] >= dsh_reg)
                    begin
                        drem_reg[n] <= drem_reg[n] - dsh_reg;
                        q_reg[n]    <= {q_reg[n][QW-2:0], 1'b1};
                    end
                    else
                    begin
                        q_reg[n] <= {q_reg[n][QW-2:0], 1'b0};
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // round-to-nearest quotient, then clamp to the Q1.15 range
    always_comb
    begin
        for (int n = 0; n < 3; n++)
        begin
            if (neg_reg[n])
            begin
                nrm[n] = (q_reg[n] > {1'b1, {(QW-1){1'b0}}}) ? {1'b1, {(QW-1){1'b0}}}
                                                               : ~q_reg[n] + 1'b1;
            end
            else
            begin
                nrm[n] = (q_reg[n] > {1'b0, {(QW-1){1'b1}}}) ? {1'b0, {(QW-1){1'b1}}}
                                                               : q_reg[n];
            end
        end
    end

    assign done           = (state_reg == N_FIN);
    assign res.degenerate = (root_reg == '0);
    assign res.x          = res.degenerate ? '0 : nrm[0];
    assign res.y          = res.degenerate ? '0 : nrm[1];
    assign res.z          = res.degenerate ? '0 : nrm[2];
    assign res.mag        = (|root_reg[AW-1:mvna_pkg::MAG_W]) ? '1
                                                             : root_reg[mvna_pkg::MAG_W-1:0];
endmodule

// ===== rtl/mvna_engine.sv =====
// Back end: index reduction, position and accumulator memories, cross product,
// saturating accumulation and result register. Depends on mvna_pkg, mvna_norm and the macros header.
`timescale 1ns / 1ps
`include "mesh_vertex_normal_accumulator_unit_macros.svh"
module mvna_engine #(
    parameter int VERTEX_COUNT = mvna_pkg::VERTEX_COUNT_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_ready,
    input  mvna_pkg::cmd_t  cmd,
    output logic            clearing,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output mvna_pkg::rsp_t  rsp
);
    localparam int AW    = $clog2(VERTEX_COUNT);
    localparam int VCW   = $clog2(VERTEX_COUNT + 1);
    localparam int IW    = mvna_pkg::IDX_W;
    localparam int MODW  = VCW + IW;
    localparam int RSH   = 2 * IW;
    localparam int QPW   = IW + RSH;
    localparam int PSW   = mvna_pkg::POS_W;
    localparam int DW    = mvna_pkg::DIFF_W;
    localparam int PRW   = mvna_pkg::PROD_W;
    localparam int CRW   = mvna_pkg::CROSS_W;
    localparam int ACW   = mvna_pkg::ACC_W;

    // ceil(2^RSH / VERTEX_COUNT): exact floor quotient for any IW-bit index
    localparam logic [RSH-1:0] VC_RECIP = RSH'((2**RSH + VERTEX_COUNT - 1) / VERTEX_COUNT);
    // only the low bits matter, the remainder is below 2^IW
    localparam logic [IW-1:0]  VC_LOW   = IW'(VERTEX_COUNT);

    typedef enum logic [9:0] {
        S_CLEAR = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_MOD   = 10'b0000000100,
        S_LOAD  = 10'b0000001000,
        S_FPOS  = 10'b0000010000,
        S_FMUL  = 10'b0000100000,
        S_FACC  = 10'b0001000000,
        S_RACC  = 10'b0010000000,
        S_NORM  = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } state_t;

    state_t                 state_reg, state_next;
    logic [2:0]             ph_reg, ph_next;
    logic [AW-1:0]          clr_reg, clr_next;
    logic                   rsp_valid_reg, rsp_valid_next;
    mvna_pkg::cmd_t         cmd_reg;
    mvna_pkg::rsp_t         rsp_reg;
    logic [IW-1:0]          r_reg [3];
    logic [IW-1:0]          quo_reg [3];
    logic [QPW-1:0]         quo_prod [3];
    logic [IW-1:0]          r_step [3];
    logic [AW-1:0]          lane_addr [3];
    logic                   idx_ok;
    logic [3*PSW-1:0]       pa_reg;
    logic signed [DW-1:0]   d1_reg [3];
    logic signed [DW-1:0]   d2_reg [3];
    logic signed [PRW-1:0]  prod_reg;
    logic signed [CRW-1:0]  c_reg [3];

    logic [3*PSW-1:0]       pos_mem [VERTEX_COUNT];
    logic [3*ACW-1:0]       acc_mem [VERTEX_COUNT];
    logic [3*PSW-1:0]       pos_rd_reg;
    logic [3*ACW-1:0]       acc_rd_reg;
    logic                   pos_we, acc_we;
    logic [AW-1:0]          pos_waddr, pos_raddr, acc_waddr, acc_raddr;
    logic [3*PSW-1:0]       pos_wdata;
    logic [3*ACW-1:0]       acc_wdata, acc_sum;

    logic signed [DW-1:0]   mul_a, mul_b;
    logic signed [PRW-1:0]  mul_p;
    logic                   norm_start, norm_done;
    logic signed [ACW-1:0]  norm_v [3];
    mvna_pkg::norm_res_t    norm_res;
    mvna_pkg::rsp_t         rsp_new;
    logic                   out_free;

    function automatic logic [ACW-1:0] sat_add(input logic signed [ACW-1:0] a,
                                               input logic signed [CRW-1:0] d);
        logic signed [ACW:0] s;
        s = (ACW+1)'(a) + (ACW+1)'(d);
        if (s[ACW] != s[ACW-1])
        begin
            sat_add = s[ACW] ? {1'b1, {(ACW-1){1'b0}}} : {1'b0, {(ACW-1){1'b1}}};
        end
        else
        begin
            sat_add = s[ACW-1:0];
        end
    endfunction

    // index modulo VERTEX_COUNT: reciprocal multiply, then multiply-subtract
    always_comb
    begin
        for (int n = 0; n < 3; n++)
        begin
            quo_prod[n]  = QPW'(r_reg[n]) * QPW'(VC_RECIP);
            r_step[n]    = r_reg[n] - IW'(quo_reg[n] * VC_LOW);
            lane_addr[n] = AW'(r_reg[n]);
        end
    end

    assign idx_ok = (MODW'(r_reg[0]) < MODW'(VERTEX_COUNT)) &&
                    (MODW'(r_reg[1]) < MODW'(VERTEX_COUNT)) &&
                    (MODW'(r_reg[2]) < MODW'(VERTEX_COUNT));

    always_comb
    begin
        for (int n = 0; n < 3; n++)
        begin
            acc_sum[n*ACW +: ACW] = sat_add(acc_rd_reg[n*ACW +: ACW], c_reg[n]);
        end
    end

    always_comb
    begin
        pos_we    = 1'b0;
        pos_waddr = lane_addr[0];
        pos_wdata = {cmd_reg.pos_z, cmd_reg.pos_y, cmd_reg.pos_x};
        pos_raddr = lane_addr[0];
        acc_we    = 1'b0;
        acc_waddr = lane_addr[0];
        acc_wdata = '0;
        acc_raddr = lane_addr[0];
        unique case (state_reg)
            S_CLEAR:
            begin
                acc_we    = 1'b1;
                acc_waddr = clr_reg;
            end
            S_LOAD:
            begin
                pos_we = 1'b1;
                acc_we = 1'b1;
            end
            S_FPOS:
            begin
                case (ph_reg)
                    3'd0:    pos_raddr = lane_addr[0];
                    3'd1:    pos_raddr = lane_addr[1];
                    default: pos_raddr = lane_addr[2];
                endcase
            end
            S_FACC:
            begin
                case (ph_reg) inside
                    3'd0, 3'd1: begin acc_raddr = lane_addr[0]; acc_waddr = lane_addr[0]; end
                    3'd2, 3'd3: begin acc_raddr = lane_addr[1]; acc_waddr = lane_addr[1]; end
                    default:    begin acc_raddr = lane_addr[2]; acc_waddr = lane_addr[2]; end
                endcase
                acc_we    = ph_reg[0];
                acc_wdata = acc_sum;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pos_we)
        begin
            pos_mem[pos_waddr] <= pos_wdata;
        end
        pos_rd_reg <= pos_mem[pos_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (acc_we)
        begin
            acc_mem[acc_waddr] <= acc_wdata;
        end
        acc_rd_reg <= acc_mem[acc_raddr];
    end

    // one shared 17x17 multiplier for the six cross-product terms
    always_comb
    begin
        case (ph_reg)
            3'd0:    begin mul_a = d1_reg[1]; mul_b = d2_reg[2]; end
            3'd1:    begin mul_a = d1_reg[2]; mul_b = d2_reg[1]; end
            3'd2:    begin mul_a = d1_reg[2]; mul_b = d2_reg[0]; end
            3'd3:    begin mul_a = d1_reg[0]; mul_b = d2_reg[2]; end
            3'd4:    begin mul_a = d1_reg[0]; mul_b = d2_reg[1]; end
            default: begin mul_a = d1_reg[1]; mul_b = d2_reg[0]; end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        for (int n = 0; n < 3; n++)
        begin
            norm_v[n] = (cmd_reg.kind == mvna_pkg::CMD_FACE) ? ACW'(c_reg[n])
                                                             : signed'(acc_rd_reg[n*ACW +: ACW]);
        end
    end

    assign norm_start = ((state_reg == S_FACC) && (ph_reg == 3'd5)) ||
                        ((state_reg == S_RACC) && (ph_reg == 3'd1));

    mvna_norm u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .start (norm_start),
        .vx    (norm_v[0]),
        .vy    (norm_v[1]),
        .vz    (norm_v[2]),
        .done  (norm_done),
        .res   (norm_res)
    );

    assign rsp_new.normal_x   = norm_res.x;
    assign rsp_new.normal_y   = norm_res.y;
    assign rsp_new.normal_z   = norm_res.z;
    assign rsp_new.magnitude  = norm_res.mag;
    assign rsp_new.degenerate = norm_res.degenerate;
    assign rsp_new.from_face  = (cmd_reg.kind == mvna_pkg::CMD_FACE);

    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign cmd_ready = (state_reg == S_IDLE);
    assign clearing  = (state_reg == S_CLEAR);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        ph_next        = ph_reg;
        clr_next       = clr_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        unique case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(VERTEX_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    ph_next    = '0;
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                ph_next = ph_reg + 1'b1;
                if (ph_reg == 3'd1)
                begin
                    ph_next = '0;
                    unique case (cmd_reg.kind)
                        mvna_pkg::CMD_LOAD: state_next = S_LOAD;
                        mvna_pkg::CMD_FACE: state_next = S_FPOS;
                        default:            state_next = S_RACC;
                    endcase
                end
            end
            S_LOAD:
            begin
                state_next = S_IDLE;
            end
            S_FPOS:
            begin
                ph_next = ph_reg + 1'b1;
                if (ph_reg == 3'd3)
                begin
                    ph_next    = '0;
                    state_next = S_FMUL;
                end
            end
            S_FMUL:
            begin
                ph_next = ph_reg + 1'b1;
                if (ph_reg == 3'd6)
                begin
                    ph_next    = '0;
                    state_next = S_FACC;
                end
            end
            S_FACC:
            begin
                ph_next = ph_reg + 1'b1;
                if (ph_reg == 3'd5)
                begin
                    state_next = S_NORM;
                end
            end
            S_RACC:
            begin
                ph_next = ph_reg + 1'b1;
                if (ph_reg == 3'd1)
                begin
                    state_next = S_NORM;
                end
            end
            S_NORM:
            begin
                if (norm_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            ph_reg        <= '0;
            clr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ph_reg        <= ph_next;
            clr_reg       <= clr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_reg  <= cmd;
                    r_reg[0] <= cmd.idx_a;
                    r_reg[1] <= cmd.idx_b;
                    r_reg[2] <= cmd.idx_c;
                end
            end
            S_MOD:
            begin
                for (int n = 0; n < 3; n++)
                begin
                    if (ph_reg == 3'd0)
                    begin
                        quo_reg[n] <= quo_prod[n][QPW-1 -: IW];
                    end
                    else
                    begin
                        r_reg[n] <= r_step[n];
                    end
                end
            end
            S_FPOS:
            begin
                case (ph_reg)
                    3'd1:
                    begin
                        pa_reg <= pos_rd_reg;
                    end
                    3'd2:
                    begin
                        for (int k = 0; k < 3; k++)
                        begin
                            d1_reg[k] <= DW'(signed'(pa_reg[k*PSW +: PSW]))
                                       - DW'(signed'(pos_rd_reg[k*PSW +: PSW]));
                        end
                    end
                    3'd3:
                    begin
                        for (int k = 0; k < 3; k++)
                        begin
                            d2_reg[k] <= DW'(signed'(pa_reg[k*PSW +: PSW]))
                                       - DW'(signed'(pos_rd_reg[k*PSW +: PSW]));
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_FMUL:
            begin
                prod_reg <= mul_p;
                case (ph_reg)
                    3'd1:    c_reg[0] <= CRW'(prod_reg);
                    3'd2:    c_reg[0] <= c_reg[0] - CRW'(prod_reg);
                    3'd3:    c_reg[1] <= CRW'(prod_reg);
                    3'd4:    c_reg[1] <= c_reg[1] - CRW'(prod_reg);
                    3'd5:    c_reg[2] <= CRW'(prod_reg);
                    3'd6:    c_reg[2] <= c_reg[2] - CRW'(prod_reg);
                    default: ;
                endcase
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    rsp_reg <= rsp_new;
                end
            end
            default:
            begin
            end
        endcase
    end

    `MVNA_ASSERT_IMP(a_norm_done_waited, clk, rst_n, norm_done, state_reg == S_NORM)
    `MVNA_ASSERT_IMP(a_acc_rmw_order, clk, rst_n, (state_reg == S_FACC) && acc_we, ph_reg[0])
    `MVNA_ASSERT_NXT(a_index_reduced, clk, rst_n, (state_reg == S_MOD) && (ph_reg == 3'd1), idx_ok)
endmodule

// ===== rtl/mesh_vertex_normal_accumulator_unit.sv =====
// Top level of the mesh vertex normal accumulator.
// Depends on mvna_pkg, mvna_front, mvna_engine (which holds mvna_norm).
`timescale 1ns / 1ps
// Area-weighted vertex normals in fixed point. A load transfer stores a Q1.15
// position and clears that vertex's accumulator; a face transfer forms the
// exact cross product (a-b)x(a-c), returns its unit vector and length (twice
// the area) and adds it, saturating at 48 bits, to all three vertices; a read
// returns a vertex's unit accumulated normal. Indices wrap modulo
// VERTEX_COUNT. Requests queue in a two-entry buffer in front of a sequential
// back end that handles one command at a time; for a zero vector the divide
// is skipped. The index reduction is a reciprocal multiply, then a
// multiply-subtract, and the longest part of a result is the 48-step
// bit-serial square root in the normalising unit, followed by three parallel
// serial dividers. After reset the accumulator memory is swept to zero, one
// entry a cycle, during which req_ready stays low. The result sits in an
// output register, so the next request transfer is taken while a result waits.
module mesh_vertex_normal_accumulator_unit #(
    parameter int VERTEX_COUNT = mvna_pkg::VERTEX_COUNT_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  mvna_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output mvna_pkg::rsp_t  rsp
);
    // command queue between front and back ends
    logic            cmd_valid;
    logic            cmd_ready;
    mvna_pkg::cmd_t  cmd;
    // back end busy clearing its accumulators
    logic            clearing;

    mvna_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .hold      (clearing),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    mvna_engine #(
        .VERTEX_COUNT (VERTEX_COUNT)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .clearing  (clearing),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );
endmodule
